/* rtl/tcs_pkg.sv */
// Shared types, constants and helper functions of the timed counting semaphore.
`default_nettype none

package tcs_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int TICK_WIDTH  = 16;
  localparam int ID_W        = 8;
  localparam int LIMIT_IN_W  = 16;
  localparam int COUNT_W     = 16;
  localparam int INIT_W      = 15;
  localparam int EVENT_W     = 3;
  localparam int PTR_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

  typedef enum logic [1:0] {
    REQ_WAIT   = 2'd0,
    REQ_SIGNAL = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_GRANTED    = 3'd0,
    EV_BLOCKED    = 3'd1,
    EV_WOKEN      = 3'd2,
    EV_TIMED_OUT  = 3'd3,
    EV_NO_WAITER  = 3'd4,
    EV_TICK_DONE  = 3'd5,
    EV_QUEUE_FULL = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SIGNAL,
    ST_TICK,
    ST_TICK_END
  } state_e;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [ID_W-1:0]       thread_id;
    logic [LIMIT_IN_W-1:0] wait_limit;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]        event_res;
    logic [ID_W-1:0]           woken_thread;
    logic                      wait_ok;
    logic signed [COUNT_W-1:0] count_now;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [TICK_WIDTH-1:0] limit;
    logic [TICK_WIDTH-1:0] elapsed;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_head;
    logic latch_req;
    logic do_wait;
    logic do_signal;
    logic tick_init;
    logic tick_issue;
    logic tick_proc;
    logic tick_finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic more;
    logic expired;
  } status_t;

  // Takes the limit modulo 2^TICK_WIDTH, zero-extending when the tick is wider.
  function automatic logic [TICK_WIDTH-1:0] tick_limit(input logic [LIMIT_IN_W-1:0] v);
    logic [TICK_WIDTH-1:0] r;
    r = '0;
    for (int b = 0; b < TICK_WIDTH; b++) begin
      if (b < LIMIT_IN_W) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

  // Advances a queue pointer around the circular buffer.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(MAX_WAITERS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tcs_ctrl.sv */
// Controller state machine of the timed counting semaphore.
`default_nettype none

module tcs_ctrl
  import tcs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] in_type_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   pv_q, pv_d;
  logic   accept;
  logic   stall;
  logic   issue;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // The read register holds an entry that cannot move on while its timeout
  // transfer has no room in the output register.
  assign stall = pv_q && status_i.expired && !status_i.out_free;
  assign issue = (state_q == ST_TICK) && !stall && status_i.more;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_type_i)
            REQ_WAIT:   state_d = ST_WAIT;
            REQ_SIGNAL: state_d = ST_SIGNAL;
            REQ_TICK:   state_d = ST_TICK;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_WAIT, ST_SIGNAL, ST_TICK_END: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (!stall && !status_i.more) begin
          state_d = ST_TICK_END;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    pv_d             = 1'b0;
    cmd_o.latch_req  = accept;
    cmd_o.tick_init  = accept && (in_type_i == REQ_TICK);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.rd_head = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.do_wait = status_i.out_free;
      end
      ST_SIGNAL: begin
        cmd_o.do_signal = status_i.out_free;
      end
      ST_TICK: begin
        cmd_o.tick_proc  = pv_q && !stall;
        cmd_o.tick_issue = issue;
        pv_d             = stall || issue;
      end
      ST_TICK_END: begin
        cmd_o.tick_finish = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
    end
  end

  a_pv_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == ST_TICK))
    else $error("entry pending outside a tick walk");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_type_i == REQ_WAIT || in_type_i == REQ_SIGNAL ||
                in_type_i == REQ_TICK)) |=> !in_ready_o)
    else $error("controller stayed ready after taking a request");

  a_end_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK_END && status_i.out_free) |=> (state_q == ST_IDLE))
    else $error("tick did not finish after its done transfer");

endmodule

`default_nettype wire

/* rtl/tcs_dp.sv */
// Datapath of the timed counting semaphore: count, waiter queue memory, output register.
`default_nettype none

module tcs_dp
  import tcs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [INIT_W-1:0]   cfg_wdata_i,
  input  wire in_item_t            in_data_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output out_item_t                out_data_o,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o
);

  entry_t mem [MAX_WAITERS];

  logic signed [COUNT_W-1:0] sem_q, sem_d;
  logic [CNT_W-1:0]          len_q, len_d;
  logic [PTR_W-1:0]          head_q, head_d;
  logic [PTR_W-1:0]          tail_q, tail_d;
  logic [PTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]          issued_q, issued_d;
  logic [CNT_W-1:0]          keep_q, keep_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;
  logic [ID_W-1:0]           req_id_q, req_id_d;
  logic [TICK_WIDTH-1:0]     req_lim_q, req_lim_d;
  entry_t                    rdata_q;

  logic                      mem_we;
  logic [PTR_W-1:0]          mem_waddr;
  entry_t                    mem_wdata;
  logic                      mem_re;
  logic [PTR_W-1:0]          mem_raddr;

  logic [TICK_WIDTH-1:0]     elapsed_inc;
  logic                      expired;
  entry_t                    aged;
  logic                      out_free;

  logic                      emit;
  event_e                    ev;
  logic [ID_W-1:0]           ev_tid;
  logic                      ev_ok;
  logic                      ev_last;

  assign elapsed_inc = rdata_q.elapsed + 1'b1;
  assign expired     = (rdata_q.limit != '0) && (elapsed_inc == rdata_q.limit);

  always_comb begin
    aged = rdata_q;
    if (rdata_q.limit != '0) begin
      aged.elapsed = elapsed_inc;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.out_free = out_free;
  assign status_o.more     = issued_q < len_q;
  assign status_o.expired  = expired;

  assign mem_re    = cmd_i.rd_head || cmd_i.tick_issue;
  assign mem_raddr = cmd_i.tick_issue ? rd_ptr_q : head_q;

  always_comb begin
    sem_d       = sem_q;
    len_d       = len_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    issued_d    = issued_q;
    keep_d      = keep_q;
    req_id_d    = req_id_q;
    req_lim_d   = req_lim_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr_q;
    mem_wdata   = aged;
    emit        = 1'b0;
    ev          = EV_GRANTED;
    ev_tid      = '0;
    ev_ok       = 1'b0;
    ev_last     = 1'b1;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cfg_we_i) begin
      sem_d  = $signed({1'b0, cfg_wdata_i});
      len_d  = '0;
      head_d = '0;
      tail_d = '0;
    end

    if (cmd_i.latch_req) begin
      req_id_d  = in_data_i.thread_id;
      req_lim_d = tick_limit(in_data_i.wait_limit);
    end

    if (cmd_i.do_wait) begin
      emit   = 1'b1;
      ev_tid = req_id_q;
      priority if (sem_q > 0) begin
        sem_d = sem_q - 16'sd1;
        ev    = EV_GRANTED;
        ev_ok = 1'b1;
      end else if (len_q == CNT_W'(MAX_WAITERS)) begin
        ev = EV_QUEUE_FULL;
      end else begin
        sem_d     = sem_q - 16'sd1;
        mem_we    = 1'b1;
        mem_waddr = tail_q;
        mem_wdata = '{id: req_id_q, limit: req_lim_q, elapsed: '0};
        tail_d    = ptr_inc(tail_q);
        len_d     = len_q + 1'b1;
        ev        = EV_BLOCKED;
      end
    end

    if (cmd_i.do_signal) begin
      emit = 1'b1;
      if (len_q == '0) begin
        if (sem_q != COUNT_MAX) begin
          sem_d = sem_q + 16'sd1;
        end
        ev = EV_NO_WAITER;
      end else begin
        sem_d  = sem_q + 16'sd1;
        head_d = ptr_inc(head_q);
        len_d  = len_q - 1'b1;
        ev     = EV_WOKEN;
        ev_tid = rdata_q.id;
        ev_ok  = 1'b1;
      end
    end

    if (cmd_i.tick_init) begin
      rd_ptr_d = head_q;
      wr_ptr_d = head_q;
      issued_d = '0;
      keep_d   = '0;
    end

    if (cmd_i.tick_issue) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      issued_d = issued_q + 1'b1;
    end

    // Survivors are written back behind the read pointer, so the queue is
    // compacted in place without disturbing entries not yet read.
    if (cmd_i.tick_proc) begin
      if (expired) begin
        sem_d   = sem_q + 16'sd1;
        emit    = 1'b1;
        ev      = EV_TIMED_OUT;
        ev_tid  = rdata_q.id;
        ev_last = 1'b0;
      end else begin
        mem_we   = 1'b1;
        wr_ptr_d = ptr_inc(wr_ptr_q);
        keep_d   = keep_q + 1'b1;
      end
    end

    if (cmd_i.tick_finish) begin
      len_d  = keep_q;
      tail_d = wr_ptr_q;
      emit   = 1'b1;
      ev     = EV_TICK_DONE;
    end

    if (emit) begin
      out_valid_d        = 1'b1;
      out_d.event_res    = ev;
      out_d.woken_thread = ev_tid;
      out_d.wait_ok      = ev_ok;
      out_d.count_now    = sem_d;
      out_d.last         = ev_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_q       <= '0;
      len_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      issued_q    <= '0;
      keep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sem_q       <= sem_d;
      len_q       <= len_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      issued_q    <= issued_d;
      keep_q      <= keep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    req_id_q  <= req_id_d;
    req_lim_q <= req_lim_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(MAX_WAITERS))
    else $error("queue length beyond capacity");

  a_count_with_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (sem_q <= 0))
    else $error("positive count while threads are queued");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written over an untaken transfer");

endmodule

`default_nettype wire

/* rtl/timed_counting_semaphore_core.sv */
// Top level of the timed counting semaphore: controller plus datapath.
`default_nettype none

// One counting semaphore with a FIFO of up to MAX_WAITERS blocked threads,
// each with its own tick timeout. Requests are taken one at a time. A wait
// or a signal passes through its own state into the output register, and is
// held back while that register still holds an untaken transfer. A tick
// walks the queued waiters in order: the queue lives in a
// single-port-read memory, and the walk reads one waiter per cycle, writing
// survivors back in order and giving one timeout result per expired waiter
// before the done marker. A stalled output pauses the walk. A write to the
// initial count register reloads the count and empties the queue at once.
module timed_counting_semaphore_core
  import tcs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [INIT_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o
);

  cmd_t    cmd;
  status_t status;

  tcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_type_i  (in_data_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

/* tb/tcs_checker.sv */
`timescale 1ns / 1ps
// Checker for the timed counting semaphore: predicts every result and compares transfers.
module tcs_checker
  import tcs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [INIT_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire in_item_t          in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire out_item_t         out_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  logic signed [COUNT_W-1:0] sem_count = '0;
  entry_t                    waiters[$];
  out_item_t                 expected_events[$];
  out_item_t                 want;
  int                        fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Every result carries the count as it stands right after its event.
  function automatic void note_event(input event_e ev, input logic [ID_W-1:0] tid,
                                     input logic ok, input logic lst);
    out_item_t r;
    r.event_res    = ev;
    r.woken_thread = tid;
    r.wait_ok      = ok;
    r.count_now    = sem_count;
    r.last         = lst;
    expected_events.push_back(r);
  endfunction

  function automatic void predict_request(input in_item_t item);
    entry_t w;
    entry_t kept[$];
    bit     expired;
    case (item.req_type)
      REQ_WAIT: begin
        if (sem_count > 0) begin
          sem_count = sem_count - 1;
          note_event(EV_GRANTED, item.thread_id, 1'b1, 1'b1);
        end else if (waiters.size() >= MAX_WAITERS) begin
          note_event(EV_QUEUE_FULL, item.thread_id, 1'b0, 1'b1);
        end else begin
          sem_count = sem_count - 1;
          w.id      = item.thread_id;
          w.limit   = item.wait_limit;
          w.elapsed = '0;
          waiters.push_back(w);
          note_event(EV_BLOCKED, item.thread_id, 1'b0, 1'b1);
        end
      end
      REQ_SIGNAL: begin
        if (waiters.size() == 0) begin
          if (sem_count < COUNT_MAX) begin
            sem_count = sem_count + 1;
          end
          note_event(EV_NO_WAITER, '0, 1'b0, 1'b1);
        end else begin
          w = waiters.pop_front();
          sem_count = sem_count + 1;
          note_event(EV_WOKEN, w.id, 1'b1, 1'b1);
        end
      end
      REQ_TICK: begin
        // Waiters with a zero limit never age; the rest time out in queue order.
        foreach (waiters[i]) begin
          w       = waiters[i];
          expired = 1'b0;
          if (w.limit != '0) begin
            w.elapsed = w.elapsed + 1'b1;
            expired   = (w.elapsed == w.limit);
          end
          if (expired) begin
            sem_count = sem_count + 1;
            note_event(EV_TIMED_OUT, w.id, 1'b0, 1'b0);
          end else begin
            kept.push_back(w);
          end
        end
        waiters = kept;
        note_event(EV_TICK_DONE, '0, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_count = '0;
      waiters.delete();
      expected_events.delete();
    end else begin
      if (cfg_we_i) begin
        sem_count = COUNT_W'(cfg_wdata_i);
        waiters.delete();
      end
      if (in_valid_i && in_ready_i) begin
        predict_request(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          fails++;
          $display("%0t: unexpected result transfer: ev=%0d thread=%0d ok=%0b count=%0d last=%0b",
                   $time, out_data_i.event_res, out_data_i.woken_thread, out_data_i.wait_ok,
                   out_data_i.count_now, out_data_i.last);
        end else begin
          want = expected_events.pop_front();
          if (out_data_i.event_res !== want.event_res ||
              out_data_i.woken_thread !== want.woken_thread ||
              out_data_i.wait_ok !== want.wait_ok ||
              out_data_i.count_now !== want.count_now ||
              out_data_i.last !== want.last) begin
            fails++;
            $display("%0t: mismatch: expected ev=%0d thread=%0d ok=%0b count=%0d last=%0b",
                     $time, want.event_res, want.woken_thread, want.wait_ok,
                     want.count_now, want.last);
            $display("%0t:           actual ev=%0d thread=%0d ok=%0b count=%0d last=%0b",
                     $time, out_data_i.event_res, out_data_i.woken_thread, out_data_i.wait_ok,
                     out_data_i.count_now, out_data_i.last);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_events.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top of the timed counting semaphore testbench: clock, reset, stimulus and verdict.
module tb;
  import tcs_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 25;
  localparam int PHASE_ITEMS   = 155;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [INIT_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;

  int fail_count;
  int pending_events;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  timed_counting_semaphore_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  tcs_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_events)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[timed_counting_semaphore_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_quiet();
    in_valid_i <= 1'b0;
    while (pending_events != 0) @(negedge clk_i);
    // A trailing ignored request may still be in flight without any result.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_initial_count(input logic [INIT_W-1:0] value);
    wait_for_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic in_item_t random_request(input logic [1:0] kind);
    in_item_t item;
    item.req_type   = kind;
    item.thread_id  = 8'($urandom_range(0, 255));
    item.wait_limit = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    return item;
  endfunction

  task automatic run_random_phase(input int sender_idle, input int receiver_idle,
                                  input int start_count);
    int       sent;
    int       burst;
    int       pick;
    in_item_t item;
    load_initial_count(INIT_W'(start_count));
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    // Opening run of waits overruns the queue, whatever the starting count.
    burst = start_count + MAX_WAITERS + $urandom_range(1, 3);
    repeat (burst) send_request(random_request(REQ_WAIT));
    sent = burst;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        burst = $urandom_range(1, 20);
      end else if (pick < 65) begin
        burst = $urandom_range(1, 6);
      end else if (pick < 92) begin
        burst = $urandom_range(1, 4);
      end else begin
        burst = 1;
      end
      repeat (burst) begin
        if (pick < 45) begin
          item = random_request(REQ_WAIT);
        end else if (pick < 65) begin
          item = random_request(REQ_SIGNAL);
        end else if (pick < 92) begin
          item = random_request(REQ_TICK);
        end else begin
          item = random_request(2'($urandom_range(0, 3)));
        end
        send_request(item);
        if (item.req_type != REQ_UNUSED) begin
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    load_initial_count('0);
    send_request(in_item_t'{REQ_SIGNAL, 8'h00, 16'h0000});
    send_request(in_item_t'{REQ_WAIT,   8'hFF, 16'hFFFF});
    send_request(in_item_t'{REQ_WAIT,   8'h00, 16'h0000});
    send_request(in_item_t'{REQ_WAIT,   8'h5A, 16'h0001});
    send_request(in_item_t'{REQ_WAIT,   8'hA5, 16'h0002});
    send_request(in_item_t'{REQ_WAIT,   8'h3C, 16'hFFFF});
    send_request(in_item_t'{REQ_TICK,   8'hFF, 16'hFFFF});
    send_request(in_item_t'{REQ_TICK,   8'h00, 16'h0000});
    send_request(in_item_t'{REQ_SIGNAL, 8'hFF, 16'hFFFF});
    send_request(in_item_t'{REQ_SIGNAL, 8'h00, 16'h0000});
    send_request(in_item_t'{REQ_TICK,   8'h00, 16'h0000});
    send_request(in_item_t'{REQ_UNUSED, 8'hFF, 16'hFFFF});

    // At the top of the count range a signal with no waiter saturates.
    load_initial_count(INIT_W'(COUNT_MAX));
    send_request(in_item_t'{REQ_SIGNAL, 8'h00, 16'h0000});
    send_request(in_item_t'{REQ_WAIT,   8'h81, 16'h8000});
    send_request(in_item_t'{REQ_SIGNAL, 8'h00, 16'h0000});
    send_request(in_item_t'{REQ_SIGNAL, 8'h00, 16'h0000});

    run_random_phase(11, 62, 0);
    run_random_phase(62, 11, $urandom_range(1, 4));
    run_random_phase(0, 0, $urandom_range(0, 2));

    wait_for_quiet();
    if (fail_count == 0 && pending_events == 0) begin
      $display("[timed_counting_semaphore_core] OK");
    end else begin
      $display("[timed_counting_semaphore_core] ERROR");
    end
    $finish;
  end

endmodule
